/* hw/rtl/vzlt_pkg.sv */
// ============================================================================
// vzlt_pkg
// Shared types, codes and reset values of the voxel zone level table.
// ============================================================================
`default_nettype none

package vzlt_pkg;

  // Default grid geometry and table layout
  localparam int LENGTH_CELLS_DEF = 64;
  localparam int WIDTH_CELLS_DEF  = 64;
  localparam int HEIGHT_CELLS_DEF = 16;
  localparam int LEVEL_BITS_DEF   = 2;
  localparam int MODE_COUNT_DEF   = 3;
  localparam int QUEUE_DEPTH_DEF  = 2;

  // Configuration reset values
  localparam logic signed [15:0] X_MIN_RST  = -16'sd10000;
  localparam logic signed [15:0] Y_MIN_RST  = -16'sd10000;
  localparam logic signed [15:0] Z_MIN_RST  = -16'sd2000;
  localparam logic        [15:0] X_SPAN_RST = 16'd20000;
  localparam logic        [15:0] Y_SPAN_RST = 16'd20000;
  localparam logic        [15:0] Z_SPAN_RST = 16'd4000;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_X_MIN  = 3'd0,
    REG_Y_MIN  = 3'd1,
    REG_Z_MIN  = 3'd2,
    REG_X_SPAN = 3'd3,
    REG_Y_SPAN = 3'd4,
    REG_Z_SPAN = 3'd5
  } reg_idx_t;

  // Classified operation handed from front to back
  typedef enum logic [1:0] {
    OP_WRITE = 2'b00,
    OP_TEST  = 2'b01,
    OP_FAIL  = 2'b10
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [1:0]  mode;
    logic [15:0] index;   // write index
    logic [1:0]  level;   // write level
    logic [15:0] dx;      // point offsets from the grid minimum, in range
    logic [15:0] dy;
    logic [15:0] dz;
  } item_t;

  typedef struct packed {
    logic [15:0] x_span;
    logic [15:0] y_span;
    logic [15:0] z_span;
  } span_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  function automatic int width_of(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/vzlt_ram.sv */
// ============================================================================
// vzlt_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module vzlt_ram
  import vzlt_pkg::*;
#(
  parameter int WIDTH = 2,
  parameter int DEPTH = 65536
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [width_of(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic                       re,
  input  logic [width_of(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/vzlt_front.sv */
// ============================================================================
// vzlt_front
// Configuration registers, input handshake and item classification.
// ============================================================================
`default_nettype none

module vzlt_front
  import vzlt_pkg::*;
#(
  parameter int MODE_COUNT  = MODE_COUNT_DEF,
  parameter int PLANE_CELLS = LENGTH_CELLS_DEF * WIDTH_CELLS_DEF * HEIGHT_CELLS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic [1:0]         mode,
  input  logic [15:0]        voxel_index,
  input  logic [1:0]         level_in,
  input  logic signed [15:0] point_x,
  input  logic signed [15:0] point_y,
  input  logic signed [15:0] point_z,
  input  back_stat_t         stat,
  input  logic               q_full,
  output logic               q_push,
  output item_t              q_item,
  output span_t              spans
);

  logic signed [15:0] x_min;
  logic signed [15:0] y_min;
  logic signed [15:0] z_min;
  logic               fr_valid;
  item_t              fr_item;
  item_t              item_next;
  logic               accept;
  logic [16:0]        dx;
  logic [16:0]        dy;
  logic [16:0]        dz;
  logic               x_ok;
  logic               y_ok;
  logic               z_ok;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      x_min         <= X_MIN_RST;
      y_min         <= Y_MIN_RST;
      z_min         <= Z_MIN_RST;
      spans.x_span  <= X_SPAN_RST;
      spans.y_span  <= Y_SPAN_RST;
      spans.z_span  <= Z_SPAN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_X_MIN:  x_min        <= cfg_data;
        REG_Y_MIN:  y_min        <= cfg_data;
        REG_Z_MIN:  z_min        <= cfg_data;
        REG_X_SPAN: spans.x_span <= cfg_data;
        REG_Y_SPAN: spans.y_span <= cfg_data;
        REG_Z_SPAN: spans.z_span <= cfg_data;
        default: ;
      endcase
    end
  end

  // Offsets from the grid minimum, one sign bit wider than the coordinates
  assign dx = {point_x[15], point_x} - {x_min[15], x_min};
  assign dy = {point_y[15], point_y} - {y_min[15], y_min};
  assign dz = {point_z[15], point_z} - {z_min[15], z_min};

  assign x_ok = !dx[16] && (dx[15:0] < spans.x_span);
  assign y_ok = !dy[16] && (dy[15:0] < spans.y_span);
  assign z_ok = !dz[16] && (dz[15:0] < spans.z_span);

  always_comb begin
    item_next.mode  = mode;
    item_next.index = voxel_index;
    item_next.level = level_in;
    item_next.dx    = dx[15:0];
    item_next.dy    = dy[15:0];
    item_next.dz    = dz[15:0];
    if ({1'b0, mode} >= 3'(MODE_COUNT)) begin
      item_next.op = OP_FAIL;
    end else if (!kind) begin
      item_next.op = (32'(voxel_index) >= 32'(PLANE_CELLS)) ? OP_FAIL : OP_WRITE;
    end else begin
      item_next.op = (x_ok && y_ok && z_ok) ? OP_TEST : OP_FAIL;
    end
  end

  assign q_push   = fr_valid && !q_full;
  assign in_ready = (!fr_valid || !q_full) && !stat.clearing;
  assign accept   = in_valid && in_ready;
  assign q_item   = fr_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (accept) begin
      fr_valid <= 1'b1;
    end else if (q_push) begin
      fr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_item <= item_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/vzlt_queue.sv */
// ============================================================================
// vzlt_queue
// Small FIFO of classified items between front and back.
// ============================================================================
`default_nettype none

module vzlt_queue
  import vzlt_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t item_in,
  output logic  full,
  input  logic  pop,
  output item_t item_out,
  output logic  nonempty
);

  localparam int PW = width_of(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  item_t         slots [DEPTH];
  logic [PW-1:0] rd_ptr;
  logic [PW-1:0] wr_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(DEPTH));
  assign nonempty = (count != '0);
  assign item_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item_in;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/vzlt_div.sv */
// ============================================================================
// vzlt_div
// Axis scaler: cell = COUNT * d / span, one quotient bit per cycle.
// ============================================================================
`default_nettype none

module vzlt_div
  import vzlt_pkg::*;
#(
  parameter int COUNT = LENGTH_CELLS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [15:0]                d,
  input  logic [15:0]                span,
  output logic                       done,
  output logic [width_of(COUNT)-1:0] quot
);

  localparam int QW = width_of(COUNT);
  localparam int NW = 16 + QW;
  localparam int CW = $clog2(QW + 1);

  logic [NW-1:0] num;
  logic [15:0]   rem;
  logic [QW-1:0] low;
  logic [CW-1:0] cnt;
  logic [16:0]   trial;
  logic          ge;

  // d < span, so the quotient stays below COUNT and the top bits start below span
  assign num   = NW'(d) * NW'(COUNT);
  assign trial = {rem, low[QW-1]};
  assign ge    = (trial >= {1'b0, span});
  assign done  = (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(QW);
    end else if (!done) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num[NW-1:QW];
      low  <= num[QW-1:0];
      quot <= '0;
    end else if (!done) begin
      rem  <= ge ? 16'(trial - {1'b0, span}) : trial[15:0];
      low  <= QW'({low, 1'b0});
      quot <= QW'({quot, ge});
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/vzlt_back.sv */
// ============================================================================
// vzlt_back
// Executes classified items: table writes, point lookups, result register.
// ============================================================================
`default_nettype none

module vzlt_back
  import vzlt_pkg::*;
#(
  parameter int LENGTH_CELLS = LENGTH_CELLS_DEF,
  parameter int WIDTH_CELLS  = WIDTH_CELLS_DEF,
  parameter int HEIGHT_CELLS = HEIGHT_CELLS_DEF,
  parameter int LEVEL_BITS   = LEVEL_BITS_DEF,
  parameter int MODE_COUNT   = MODE_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  item_t      q_item,
  output logic       q_pop,
  input  span_t      spans,
  output back_stat_t stat,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] level_out,
  output logic       failed
);

  localparam int PLANE_CELLS = LENGTH_CELLS * WIDTH_CELLS * HEIGHT_CELLS;
  localparam int IDX_W       = width_of(PLANE_CELLS);
  localparam int ROW_CELLS   = WIDTH_CELLS * HEIGHT_CELLS;
  localparam int QX          = width_of(LENGTH_CELLS);
  localparam int QY          = width_of(WIDTH_CELLS);
  localparam int QZ          = width_of(HEIGHT_CELLS);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_DIV   = 5'b00100,
    S_LOOK  = 5'b01000,
    S_DATA  = 5'b10000
  } state_t;

  state_t                 state;
  state_t                 state_next;
  logic [IDX_W-1:0]       clr_addr;
  logic [1:0]             cur_mode;
  logic                   res_free;
  logic                   res_load;
  logic [1:0]             res_level_next;
  logic                   res_fail_next;
  logic                   div_start;
  logic                   x_done;
  logic                   y_done;
  logic                   z_done;
  logic [QX-1:0]          cell_x;
  logic [QY-1:0]          cell_y;
  logic [QZ-1:0]          cell_z;
  logic [MODE_COUNT-1:0]  ram_we;
  logic [IDX_W-1:0]       wr_addr;
  logic [LEVEL_BITS-1:0]  wr_data;
  logic                   ram_re;
  logic [IDX_W-1:0]       rd_addr;
  logic [LEVEL_BITS-1:0]  rd_data [MODE_COUNT];
  logic [LEVEL_BITS-1:0]  rd_sel;

  assign res_free       = !out_valid || out_ready;
  assign stat.clearing  = (state == S_CLEAR);

  // Row-major voxel index from the three cells
  assign rd_addr = IDX_W'(cell_x) * IDX_W'(ROW_CELLS)
                 + IDX_W'(cell_y) * IDX_W'(HEIGHT_CELLS)
                 + IDX_W'(cell_z);

  always_comb begin
    rd_sel = '0;
    for (int m = 0; m < MODE_COUNT; m++) begin
      if (cur_mode == 2'(m)) begin
        rd_sel = rd_data[m];
      end
    end
  end

  always_comb begin
    state_next     = state;
    q_pop          = 1'b0;
    div_start      = 1'b0;
    res_load       = 1'b0;
    res_level_next = '0;
    res_fail_next  = 1'b0;
    ram_we         = '0;
    wr_addr        = clr_addr;
    wr_data        = '0;
    ram_re         = 1'b0;
    case (state)
      S_CLEAR: begin
        ram_we = '1;
        if (clr_addr == IDX_W'(PLANE_CELLS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          case (q_item.op)
            OP_TEST: begin
              q_pop      = 1'b1;
              div_start  = 1'b1;
              state_next = S_DIV;
            end
            OP_WRITE: begin
              if (res_free) begin
                q_pop    = 1'b1;
                res_load = 1'b1;
                wr_addr  = IDX_W'(q_item.index);
                wr_data  = LEVEL_BITS'(q_item.level);
                for (int m = 0; m < MODE_COUNT; m++) begin
                  ram_we[m] = (q_item.mode == 2'(m));
                end
              end
            end
            default: begin
              if (res_free) begin
                q_pop         = 1'b1;
                res_load      = 1'b1;
                res_fail_next = 1'b1;
              end
            end
          endcase
        end
      end
      S_DIV: begin
        if (x_done && y_done && z_done) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        ram_re     = 1'b1;
        state_next = S_DATA;
      end
      S_DATA: begin
        // hold the read data until the result register frees up
        if (res_free) begin
          res_load       = 1'b1;
          res_level_next = 2'(rd_sel);
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      cur_mode <= q_item.mode;
    end
    if (res_load) begin
      level_out <= res_level_next;
      failed    <= res_fail_next;
    end
  end

  vzlt_div #(.COUNT(LENGTH_CELLS)) u_div_x (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .d     (q_item.dx),
    .span  (spans.x_span),
    .done  (x_done),
    .quot  (cell_x)
  );

  vzlt_div #(.COUNT(WIDTH_CELLS)) u_div_y (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .d     (q_item.dy),
    .span  (spans.y_span),
    .done  (y_done),
    .quot  (cell_y)
  );

  vzlt_div #(.COUNT(HEIGHT_CELLS)) u_div_z (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .d     (q_item.dz),
    .span  (spans.z_span),
    .done  (z_done),
    .quot  (cell_z)
  );

  // One plane per mode; all planes clear in parallel after reset
  for (genvar g = 0; g < MODE_COUNT; g++) begin : g_plane
    vzlt_ram #(
      .WIDTH (LEVEL_BITS),
      .DEPTH (PLANE_CELLS)
    ) u_ram (
      .clk     (clk),
      .we      (ram_we[g]),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .re      (ram_re),
      .rd_addr (rd_addr),
      .rd_data (rd_data[g])
    );
  end

endmodule

`default_nettype wire

/* hw/rtl/voxel_zone_level_table_core.sv */
// ============================================================================
// voxel_zone_level_table_core
// Per-mode voxel table of zone levels with point-to-voxel lookup.
// ============================================================================
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------------------
//   input    | in_valid / in_ready  | kind, mode, voxel_index, level_in,
//            |                      | point_x, point_y, point_z
//   output   | out_valid / out_ready| level_out, failed
//   config   | cfg_we               | cfg_index, cfg_data
//
// A write or failing item is handled in S_IDLE once the result register is free;
// a point test runs the radix-2 axis scalers in S_DIV, followed by one
// registered table read in S_LOOK and S_DATA.
// After reset the table is cleared one voxel per cycle in every plane at once,
// all LENGTH_CELLS * WIDTH_CELLS * HEIGHT_CELLS voxels (65536 by default), with
// in_ready low throughout. A stalled output holds one result while the front
// register and the queue keep taking items.
// ============================================================================
`default_nettype none

module voxel_zone_level_table_core
  import vzlt_pkg::*;
#(
  parameter int LENGTH_CELLS = LENGTH_CELLS_DEF,
  parameter int WIDTH_CELLS  = WIDTH_CELLS_DEF,
  parameter int HEIGHT_CELLS = HEIGHT_CELLS_DEF,
  parameter int LEVEL_BITS   = LEVEL_BITS_DEF,
  parameter int MODE_COUNT   = MODE_COUNT_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic [1:0]         mode,
  input  logic [15:0]        voxel_index,
  input  logic [1:0]         level_in,
  input  logic signed [15:0] point_x,
  input  logic signed [15:0] point_y,
  input  logic signed [15:0] point_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         level_out,
  output logic               failed
);

  localparam int PLANE_CELLS = LENGTH_CELLS * WIDTH_CELLS * HEIGHT_CELLS;

  back_stat_t stat;
  span_t      spans;
  logic       q_full;
  logic       q_push;
  item_t      q_in;
  logic       q_pop;
  item_t      q_out;
  logic       q_nonempty;

  vzlt_front #(
    .MODE_COUNT  (MODE_COUNT),
    .PLANE_CELLS (PLANE_CELLS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .mode        (mode),
    .voxel_index (voxel_index),
    .level_in    (level_in),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z),
    .stat        (stat),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (q_in),
    .spans       (spans)
  );

  vzlt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .item_in  (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .item_out (q_out),
    .nonempty (q_nonempty)
  );

  vzlt_back #(
    .LENGTH_CELLS (LENGTH_CELLS),
    .WIDTH_CELLS  (WIDTH_CELLS),
    .HEIGHT_CELLS (HEIGHT_CELLS),
    .LEVEL_BITS   (LEVEL_BITS),
    .MODE_COUNT   (MODE_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_nonempty),
    .q_item    (q_out),
    .q_pop     (q_pop),
    .spans     (spans),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .level_out (level_out),
    .failed    (failed)
  );

endmodule

`default_nettype wire

/* hw/rtl/vzlt_checker.sv */
// ============================================================================
// vzlt_checker
// Port-level assertions for the voxel zone level table, bound to the top.
// ============================================================================
`default_nettype none

module vzlt_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] level_out,
  input logic       failed
);

  logic       in_acc;
  logic       out_acc;
  logic [3:0] pending;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // count transactions taken in but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_acc && !out_acc) begin
      pending <= pending + 1'b1;
    end else if (out_acc && !in_acc) begin
      pending <= pending - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(level_out) && $stable(failed))
    else $error("result changed while stalled");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && failed |-> level_out == 2'd0)
    else $error("failed result carries a level");

  a_clear_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> !in_ready)
    else $error("input taken during table clear");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 4'd0)
    else $error("result without an outstanding transaction");

endmodule

bind voxel_zone_level_table_core vzlt_checker u_vzlt_checker (.*);

`default_nettype wire

/* tb/sv/voxel_zone_level_table_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// voxel_zone_level_table_core_test
// Self-checking bench for the voxel zone level table. A short table of probes
// covers reset contents, table extremes, grid boundaries and bad modes; random
// write/test traffic then runs under several grid settings and idle patterns.
// Every result is compared with its probe row's answer or a software shadow of the level planes.
// ----------------------------------------------------------------------------
module voxel_zone_level_table_core_test;
  import vzlt_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 24;
  localparam int POOL_DEPTH      = 32;
  localparam int PLANE_CELLS     = LENGTH_CELLS_DEF * WIDTH_CELLS_DEF * HEIGHT_CELLS_DEF;
  localparam logic [1:0] LEVEL_MASK = 2'((1 << LEVEL_BITS_DEF) - 1);

  localparam bit         KIND_WRITE   = 1'b0;
  localparam bit         KIND_TEST    = 1'b1;
  localparam logic [1:0] MODE_BAD     = 2'(MODE_COUNT_DEF);
  localparam logic [2:0] SPARE_REG_LO = 3'd6;
  localparam logic [2:0] SPARE_REG_HI = 3'd7;

  typedef struct packed {
    logic               kind;
    logic [1:0]         mode;
    logic [15:0]        vidx;
    logic [1:0]         lvl;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] pz;
  } zone_item_t;

  typedef struct packed {
    logic [1:0] level;
    logic       failed;
  } lookup_result_t;

  typedef struct {
    zone_item_t     item;
    bit             known;
    lookup_result_t answer;
  } probe_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               kind = 1'b0;
  logic [1:0]         mode = '0;
  logic [15:0]        voxel_index = '0;
  logic [1:0]         level_in = '0;
  logic signed [15:0] point_x = '0;
  logic signed [15:0] point_y = '0;
  logic signed [15:0] point_z = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         level_out;
  logic               failed;

  // shadow of the level planes and grid registers
  bit [1:0]           zone_levels [MODE_COUNT_DEF][PLANE_CELLS];
  logic signed [15:0] grid_lo [3];
  logic [15:0]        grid_span [3];

  lookup_result_t pending_lookups [$];
  zone_item_t     point_pool [$];
  probe_row_t     probe_rows [$];

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_off_asked = 0;
  int hold_off_done = 0;
  int hold_off_left = 0;
  int error_count = 0;
  int cycle_count = 0;

  voxel_zone_level_table_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .mode        (mode),
    .voxel_index (voxel_index),
    .level_in    (level_in),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .level_out   (level_out),
    .failed      (failed)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("voxel_zone_level_table_core verification failed");
      $finish;
    end
  end

  // Cell number along one axis, or -1 when the coordinate lies off the grid.
  function automatic int axis_cell(input logic signed [15:0] coord,
                                   input logic signed [15:0] lo,
                                   input logic [15:0] span, input int count);
    int d;
    int bin;
    d = int'(coord) - int'(lo);
    if (span == 0 || d < 0 || d >= int'(span)) return -1;
    bin = (count * d) / int'(span);
    return (bin < count) ? bin : -1;
  endfunction

  function automatic int voxel_of(input logic signed [15:0] px, py, pz);
    int cx;
    int cy;
    int cz;
    cx = axis_cell(px, grid_lo[0], grid_span[0], LENGTH_CELLS_DEF);
    cy = axis_cell(py, grid_lo[1], grid_span[1], WIDTH_CELLS_DEF);
    cz = axis_cell(pz, grid_lo[2], grid_span[2], HEIGHT_CELLS_DEF);
    if (cx < 0 || cy < 0 || cz < 0) return -1;
    return (cx * WIDTH_CELLS_DEF + cy) * HEIGHT_CELLS_DEF + cz;
  endfunction

  // Apply one transaction to the shadow planes and return its result.
  function automatic lookup_result_t zone_lookup(input zone_item_t it);
    lookup_result_t res;
    int vox;
    res = '0;
    if (it.mode >= MODE_COUNT_DEF) begin
      res.failed = 1'b1;
    end else if (it.kind == KIND_WRITE) begin
      if (it.vidx >= PLANE_CELLS) res.failed = 1'b1;
      else zone_levels[it.mode][it.vidx] = it.lvl & LEVEL_MASK;
    end else begin
      vox = voxel_of(it.px, it.py, it.pz);
      if (vox < 0) res.failed = 1'b1;
      else res.level = zone_levels[it.mode][vox];
    end
    return res;
  endfunction

  function automatic logic signed [15:0] grid_coord(input int axis);
    int lo;
    int hi;
    if (grid_span[axis] == 0) return 16'($urandom);
    lo = int'(grid_lo[axis]);
    hi = lo + int'(grid_span[axis]) - 1;
    if (hi > 32767) hi = 32767;
    return 16'(lo + int'($urandom_range(hi - lo)));
  endfunction

  // Coordinates on and just past the grid faces, plus wild values.
  function automatic logic signed [15:0] edge_coord(input int axis);
    int lo;
    int span;
    lo = int'(grid_lo[axis]);
    span = int'(grid_span[axis]);
    case ($urandom_range(4))
      0: return 16'(lo);
      1: return 16'(lo + span - 1);
      2: return 16'(lo - 1);
      3: return 16'(lo + span);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic zone_item_t random_item();
    zone_item_t it;
    zone_item_t seen;
    int pick;
    int vox;
    it.kind = KIND_TEST;
    it.mode = 2'($urandom_range(MODE_COUNT_DEF - 1));
    it.vidx = 16'($urandom);
    it.lvl  = 2'($urandom);
    it.px   = 16'($urandom);
    it.py   = 16'($urandom);
    it.pz   = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 8) begin
      it.mode = MODE_BAD;
      it.kind = 1'($urandom);
    end else if (pick < 30) begin
      it.kind = KIND_WRITE;
    end else if (pick < 50) begin
      // write the voxel under an in-grid point and remember the point
      it.kind = KIND_WRITE;
      it.px = grid_coord(0);
      it.py = grid_coord(1);
      it.pz = grid_coord(2);
      vox = voxel_of(it.px, it.py, it.pz);
      if (vox >= 0) it.vidx = 16'(vox);
      point_pool = {point_pool, it};
      if (point_pool.size() > POOL_DEPTH) void'(point_pool.pop_front());
    end else if (pick < 75 && point_pool.size() != 0) begin
      seen = point_pool[$urandom_range(point_pool.size() - 1)];
      it.px = seen.px;
      it.py = seen.py;
      it.pz = seen.pz;
    end else if (pick < 90) begin
      it.px = grid_coord(0);
      it.py = grid_coord(1);
      it.pz = grid_coord(2);
    end else begin
      it.px = edge_coord(0);
      it.py = edge_coord(1);
      it.pz = edge_coord(2);
    end
    return it;
  endfunction

  function automatic void add_row(input bit k, input logic [1:0] m, input logic [15:0] vidx,
                                  input logic [1:0] lvl, input int px, py, pz,
                                  input bit known, input logic [1:0] lvl_exp,
                                  input bit fail_exp);
    probe_row_t row;
    row.item = '{kind: k, mode: m, vidx: vidx, lvl: lvl,
                 px: 16'(px), py: 16'(py), pz: 16'(pz)};
    row.known = known;
    row.answer = '{level: lvl_exp, failed: fail_exp};
    probe_rows = {probe_rows, row};
  endfunction

  task automatic offer(input zone_item_t it, input bit known, input lookup_result_t answer);
    lookup_result_t due;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= it.kind;
    mode        <= it.mode;
    voxel_index <= it.vidx;
    level_in    <= it.lvl;
    point_x     <= it.px;
    point_y     <= it.py;
    point_z     <= it.pz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    due = zone_lookup(it);
    if (known) due = answer;
    pending_lookups = {pending_lookups, due};
  endtask

  task automatic run_random(input int count, input int hold_at);
    for (int n = 0; n < count; n++) begin
      if (n == hold_at) hold_off_asked++;
      offer(random_item(), 1'b0, '0);
    end
  endtask

  // Drop valid, wait for every outstanding result, then let the pipe go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_X_MIN:  grid_lo[0] = data;
      REG_Y_MIN:  grid_lo[1] = data;
      REG_Z_MIN:  grid_lo[2] = data;
      REG_X_SPAN: grid_span[0] = data;
      REG_Y_SPAN: grid_span[1] = data;
      REG_Z_SPAN: grid_span[2] = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_grid(input logic [15:0] xlo, ylo, zlo, xs, ys, zs);
    write_reg(SPARE_REG_LO, 16'($urandom));
    write_reg(SPARE_REG_HI, 16'($urandom));
    write_reg(REG_X_MIN, xlo);
    write_reg(REG_Y_MIN, ylo);
    write_reg(REG_Z_MIN, zlo);
    write_reg(REG_X_SPAN, xs);
    write_reg(REG_Y_SPAN, ys);
    write_reg(REG_Z_SPAN, zs);
    cfg_we <= 1'b0;
    point_pool.delete();
  endtask

  // Result side: check each transaction, then pick the next ready level.
  always @(posedge clk) begin : result_check
    lookup_result_t due;
    if (!rst && out_valid && out_ready) begin
      if (pending_lookups.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("%0t: unexpected result level %0d failed %0d", $realtime, level_out, failed);
      end else begin
        due = pending_lookups.pop_front();
        if (level_out !== due.level || failed !== due.failed) begin
          error_count++;
          if (error_count <= 10)
            $display("%0t: mismatch level %0d/%0d failed %0d/%0d (expected/actual)",
                     $realtime, due.level, level_out, due.failed, failed);
        end
      end
    end
    if (hold_off_asked != hold_off_done) begin
      hold_off_left = HOLD_OFF_CYCLES;
      hold_off_done = hold_off_asked;
    end
    if (hold_off_left > 0) begin
      hold_off_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    grid_lo[0] = X_MIN_RST;
    grid_lo[1] = Y_MIN_RST;
    grid_lo[2] = Z_MIN_RST;
    grid_span[0] = X_SPAN_RST;
    grid_span[1] = Y_SPAN_RST;
    grid_span[2] = Z_SPAN_RST;

    // reset grid: x, y in [-10000, 10000), z in [-2000, 2000)
    add_row(KIND_TEST,  2'd0, 0, 0, 0, 0, 0, 1, 0, 0);
    add_row(KIND_TEST,  2'd2, 0, 0, 9999, 9999, 1999, 1, 0, 0);
    add_row(KIND_TEST,  MODE_BAD, 0, 0, 0, 0, 0, 1, 0, 1);
    add_row(KIND_WRITE, MODE_BAD, 5, 3, 0, 0, 0, 1, 0, 1);
    add_row(KIND_WRITE, 2'd0, 0, 3, 0, 0, 0, 1, 0, 0);
    add_row(KIND_WRITE, 2'd0, 16'hFFFF, 2, 0, 0, 0, 1, 0, 0);
    add_row(KIND_WRITE, 2'd1, 100, 1, 0, 0, 0, 1, 0, 0);
    add_row(KIND_WRITE, 2'd2, 100, 3, 0, 0, 0, 1, 0, 0);
    add_row(KIND_TEST,  2'd0, 0, 0, -10000, -10000, -2000, 0, 0, 0);
    add_row(KIND_TEST,  2'd0, 0, 0, 9999, 9999, 1999, 0, 0, 0);
    add_row(KIND_TEST,  2'd1, 0, 0, -10000, -8000, -900, 0, 0, 0);
    add_row(KIND_TEST,  2'd2, 0, 0, -10000, -8000, -900, 0, 0, 0);
    add_row(KIND_TEST,  2'd0, 0, 0, -8000, -8000, -900, 0, 0, 0);
    add_row(KIND_TEST,  2'd0, 0, 0, -10001, 0, 0, 1, 0, 1);
    add_row(KIND_TEST,  2'd0, 0, 0, 10000, 0, 0, 1, 0, 1);
    add_row(KIND_TEST,  2'd0, 0, 0, 0, -10001, 0, 1, 0, 1);
    add_row(KIND_TEST,  2'd0, 0, 0, 0, 10000, 0, 1, 0, 1);
    add_row(KIND_TEST,  2'd0, 0, 0, 0, 0, -2001, 1, 0, 1);
    add_row(KIND_TEST,  2'd0, 0, 0, 0, 0, 2000, 1, 0, 1);
    add_row(KIND_TEST,  2'd1, 0, 0, -32768, -32768, -32768, 1, 0, 1);
    add_row(KIND_TEST,  2'd2, 0, 0, 32767, 32767, 32767, 1, 0, 1);
    add_row(KIND_WRITE, 2'd0, 0, 0, 0, 0, 0, 1, 0, 0);
    add_row(KIND_TEST,  2'd0, 0, 0, -10000, -10000, -2000, 0, 0, 0);
    add_row(KIND_TEST,  MODE_BAD, 0, 0, -10000, -10000, -2000, 1, 0, 1);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // no idling; the first transaction waits out the table clear
    foreach (probe_rows[i]) offer(probe_rows[i].item, probe_rows[i].known, probe_rows[i].answer);
    run_random(100, -1);
    settle();

    // extreme grid corners, sender idle
    set_grid(16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'd1, 16'd16);
    idle_pct = 54;
    stall_pct = 0;
    run_random(100, -1);
    settle();

    // random grid, receiver stalls plus one long hold-off to back up the input
    set_grid(16'($urandom_range(30000) - 20000), 16'($urandom_range(30000) - 20000),
             16'($urandom_range(30000) - 20000), 16'($urandom_range(40000, 1)),
             16'($urandom_range(40000, 1)), 16'($urandom_range(40000, 1)));
    idle_pct = 0;
    stall_pct = 54;
    run_random(100, 10);
    settle();

    // zero height span: every point test fails
    set_grid(16'($urandom_range(20000) - 10000), 16'(Y_MIN_RST), 16'(Z_MIN_RST),
             16'd1000, Y_SPAN_RST, 16'd0);
    idle_pct = 27;
    stall_pct = 27;
    run_random(100, -1);
    settle();

    // back to the reset grid; earlier writes must still read back
    set_grid(X_MIN_RST, Y_MIN_RST, Z_MIN_RST, X_SPAN_RST, Y_SPAN_RST, Z_SPAN_RST);
    idle_pct = 0;
    stall_pct = 0;
    run_random(100, -1);
    settle();

    if (pending_lookups.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("voxel_zone_level_table_core verification clean");
    end else begin
      $display("voxel_zone_level_table_core verification failed");
    end
    $finish;
  end

endmodule
